/* design/fse_pkg.sv */
// Package for the frame signal extractor: payload structs, status codes,
// configuration register indexes and the scaler request type. No dependencies.
package fse_pkg;

  localparam int DATA_W = 64;

  localparam logic [2:0] REG_WINDOW_START = 3'd0;
  localparam logic [2:0] REG_WINDOW_COUNT = 3'd1;
  localparam logic [2:0] REG_BIT_SHIFT    = 3'd2;
  localparam logic [2:0] REG_BIT_COUNT    = 3'd3;
  localparam logic [2:0] REG_BIG_ENDIAN   = 3'd4;
  localparam logic [2:0] REG_SIGNED       = 3'd5;
  localparam logic [2:0] REG_FACTOR       = 3'd6;
  localparam logic [2:0] REG_OFFSET       = 3'd7;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_DEF = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  typedef struct packed {
    logic [63:0] payload_bytes;
    logic [3:0]  payload_length;
  } frame_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        raw_unsigned_field;
    logic signed [63:0] raw_signed_field;
    logic signed [63:0] scaled_value;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [63:0] mag;
  } scl_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] field;
    logic [63:0] sfield;
  } side_t;

endpackage

/* design/fse_scaler.sv */
// Four-stage scaler: split 64x32 multiply, signed rounding of the Q.16 product
// to an integer, offset addition and saturation to 64 bits. Depends on fse_pkg.
module fse_scaler import fse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  scl_req_t    req,
  input  logic [31:0] factor,
  input  logic [63:0] offset,
  output logic        out_valid,
  output logic [63:0] value
);

  logic        fneg;
  logic [31:0] fmag;

  logic        v4, v5, v6;
  logic        sgn4, sgn5;
  logic [63:0] pa4, pb4;
  logic [95:0] prod5;
  logic [96:0] rnd6;
  logic [80:0] q7;
  logic [81:0] sum7;
  logic [63:0] value_next;

  assign fneg = factor[31];
  assign fmag = fneg ? 32'(32'd0 - factor) : factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4 <= req.valid;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    sgn4  <= req.neg ^ fneg;
    pa4   <= 64'(req.mag[31:0]) * 64'(fmag);
    pb4   <= 64'(req.mag[63:32]) * 64'(fmag);
    sgn5  <= sgn4;
    prod5 <= {32'd0, pa4} + {pb4, 32'd0};
    rnd6  <= sgn5 ? (~{1'b0, prod5}) + 97'd32769 : {1'b0, prod5} + 97'd32768;
    value <= value_next;
  end

  always_comb begin
    q7 = rnd6[96:16];
    sum7 = {q7[80], q7} + {{18{offset[63]}}, offset};
    if ((&sum7[81:63]) || !(|sum7[81:63])) begin
      value_next = sum7[63:0];
    end else if (sum7[81]) begin
      value_next = 64'h8000_0000_0000_0000;
    end else begin
      value_next = 64'h7FFF_FFFF_FFFF_FFFF;
    end
  end

endmodule

/* design/frame_signal_extractor.sv */
// Frame signal extractor top level: configuration registers, window check,
// byte gathering and field extraction. Depends on fse_pkg and fse_scaler.
//
// A frame beat is taken at a rising edge where start is high and busy is low.
// busy is high only while rst is held, so a new frame may be offered in every
// cycle and each one gives exactly one result beat. The result appears on
// result with done high for one cycle, and in the order the frames arrived.
// The path is seven register stages deep: window check and gather, shift and
// mask, magnitude, two 32x32 partial products, product sum, rounding, and
// offset add with saturation, followed by the result register. The receiver
// cannot stall, so nothing ever backs up. Configuration is written through
// cfg_we, cfg_index and cfg_data while no frame is in flight. A synchronous
// reset returns the registers to their defaults and drops every frame in the
// pipeline. On a bad definition or a window beyond the frame the status says
// so and the value fields are zero.
module frame_signal_extractor import fse_pkg::*; #(
  parameter int FRAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  frame_t      frame,
  output logic        done,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [3:0] FRAME_LEN = 4'(FRAME_BYTES);
  localparam int SIDE_DEPTH = 4;

  logic [2:0]  window_start_byte;
  logic [3:0]  window_byte_count;
  logic [5:0]  field_bit_shift;
  logic [6:0]  field_bit_count;
  logic        big_endian_mode;
  logic        signed_mode;
  logic [31:0] scale_factor;
  logic [63:0] scale_offset;

  logic        v1, v2, v3;
  logic [1:0]  status1, status2;
  logic [63:0] word1;
  logic [63:0] field2, sfield2;
  logic [1:0]  status_next;
  logic [63:0] word_next;
  logic [63:0] mask;
  logic [63:0] field_next, sfield_next;
  logic        neg3;
  logic [63:0] mag3;
  scl_req_t    req3;
  side_t       side3;
  side_t       side_dly [SIDE_DEPTH];
  logic        scl_valid;
  logic [63:0] scl_value;
  logic        accept;

  assign busy   = rst;
  assign accept = start && !busy;
  assign req3   = '{valid: v3, neg: neg3, mag: mag3};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start_byte <= 3'd0;
      window_byte_count <= 4'd1;
      field_bit_shift   <= 6'd0;
      field_bit_count   <= 7'd8;
      big_endian_mode   <= 1'b0;
      signed_mode       <= 1'b0;
      scale_factor      <= 32'd65536;
      scale_offset      <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_START: window_start_byte <= cfg_data[2:0];
        REG_WINDOW_COUNT: window_byte_count <= cfg_data[3:0];
        REG_BIT_SHIFT:    field_bit_shift   <= cfg_data[5:0];
        REG_BIT_COUNT:    field_bit_count   <= cfg_data[6:0];
        REG_BIG_ENDIAN:   big_endian_mode   <= cfg_data[0];
        REG_SIGNED:       signed_mode       <= cfg_data[0];
        REG_FACTOR:       scale_factor      <= cfg_data[31:0];
        REG_OFFSET:       scale_offset      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [3:0] len_eff;
    logic [2:0] idx;
    len_eff = (frame.payload_length > FRAME_LEN) ? FRAME_LEN : frame.payload_length;
    if (window_byte_count == 4'd0 || window_byte_count > 4'd8 ||
        field_bit_count == 7'd0 || field_bit_count > 7'd64 ||
        (8'(field_bit_shift) + 8'(field_bit_count)) > {1'b0, window_byte_count, 3'b000}) begin
      status_next = STATUS_BAD_DEF;
    end else if ((5'(window_start_byte) + 5'(window_byte_count)) > 5'(len_eff)) begin
      status_next = STATUS_OUTSIDE;
    end else begin
      status_next = STATUS_OK;
    end
    word_next = 64'd0;
    for (int j = 0; j < 8; j++) begin
      if (big_endian_mode) begin
        idx = window_start_byte + 3'(window_byte_count - 4'd1 - 4'(j));
      end else begin
        idx = window_start_byte + 3'(j);
      end
      if (4'(j) < window_byte_count) begin
        word_next[8*j +: 8] = frame.payload_bytes[8*idx +: 8];
      end
    end
  end

  always_comb begin
    logic [63:0] shifted;
    logic [5:0]  sign_idx;
    shifted  = word1 >> field_bit_shift;
    mask     = field_bit_count[6] ? {64{1'b1}}
                                  : (64'd1 << field_bit_count[5:0]) - 64'd1;
    field_next = shifted & mask;
    sign_idx = field_bit_count[5:0] - 6'd1;
    if (signed_mode && !field_bit_count[6] && field_next[sign_idx]) begin
      sfield_next = field_next | ~mask;
    end else begin
      sfield_next = field_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      done <= scl_valid;
    end
  end

  always_ff @(posedge clk) begin
    status1  <= status_next;
    word1    <= word_next;
    status2  <= status1;
    field2   <= field_next;
    sfield2  <= sfield_next;
    neg3     <= signed_mode && sfield2[63];
    mag3     <= (signed_mode && sfield2[63]) ? 64'd0 - sfield2 : sfield2;
    side3    <= '{status: status2, field: field2, sfield: sfield2};
    side_dly[0] <= side3;
    for (int k = 1; k < SIDE_DEPTH; k++) begin
      side_dly[k] <= side_dly[k-1];
    end
    if (side_dly[SIDE_DEPTH-1].status == STATUS_OK) begin
      result <= '{status: STATUS_OK,
                  raw_unsigned_field: side_dly[SIDE_DEPTH-1].field,
                  raw_signed_field: side_dly[SIDE_DEPTH-1].sfield,
                  scaled_value: scl_value};
    end else begin
      result <= '{status: side_dly[SIDE_DEPTH-1].status,
                  raw_unsigned_field: 64'd0,
                  raw_signed_field: 64'd0,
                  scaled_value: 64'd0};
    end
  end

  fse_scaler u_scaler (
    .clk       (clk),
    .rst       (rst),
    .req       (req3),
    .factor    (scale_factor),
    .offset    (scale_offset),
    .out_valid (scl_valid),
    .value     (scl_value)
  );

endmodule

/* design/fse_checker.sv */
// Port-level checker for the frame signal extractor and its bind statement.
// Depends on fse_pkg and the frame_signal_extractor top level.
module fse_checker import fse_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##8 done)
    else $error("accepted frame gave no result beat after eight cycles");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 8))
    else $error("result beat without a matching accepted frame");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STATUS_OK |->
      result.raw_unsigned_field == 64'd0 && result.raw_signed_field == 64'sd0 &&
      result.scaled_value == 64'sd0)
    else $error("error result carries non-zero fields");

  a_sign_consistent: assert property (@(posedge clk) disable iff (rst)
    done && !result.raw_signed_field[63] |->
      result.raw_signed_field == result.raw_unsigned_field)
    else $error("non-negative signed field differs from unsigned field");

endmodule

bind frame_signal_extractor fse_checker u_fse_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for frame_signal_extractor: directed and random frames
// under many signal definitions, each result checked against a local predictor.
// Depends on fse_pkg and the frame_signal_extractor RTL.
module testbench;
  import fse_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [2:0]  win_start;
    logic [3:0]  win_count;
    logic [5:0]  shift;
    logic [6:0]  width;
    logic        big_endian;
    logic        sign_ext;
    logic [31:0] factor;
    logic [63:0] offset;
  } signal_def_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  frame_t      frame = '0;
  logic        done;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  signal_def_t active_def;
  result_t     pending_decodes[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          gap_chance = 0;

  frame_signal_extractor u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .frame(frame),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic result_t decode_signal(signal_def_t d, frame_t f);
    result_t r;
    int unsigned len, cnt, sh, wd, idx;
    logic [63:0] word, mask, field, sfield;
    logic signed [127:0] mult, fac, prod, acc;
    r = '0;
    len = (f.payload_length > 8) ? 8 : f.payload_length;
    cnt = d.win_count;
    sh = d.shift;
    wd = d.width;
    if (cnt == 0 || cnt > 8 || wd == 0 || wd > 64 || sh + wd > 8 * cnt) begin
      r.status = STATUS_BAD_DEF;
      return r;
    end
    if (d.win_start + cnt > len) begin
      r.status = STATUS_OUTSIDE;
      return r;
    end
    word = '0;
    for (int i = 0; i < cnt; i++) begin
      idx = (d.win_start + i) % 8;
      if (d.big_endian) begin
        word = {word[55:0], f.payload_bytes[8*idx +: 8]};
      end else begin
        word[8*i +: 8] = f.payload_bytes[8*idx +: 8];
      end
    end
    mask = (wd == 64) ? '1 : ((64'd1 << wd) - 64'd1);
    field = (word >> sh) & mask;
    sfield = field;
    if (d.sign_ext && wd < 64 && field[wd-1]) begin
      sfield = field | ~mask;
    end
    mult = d.sign_ext ? {{64{sfield[63]}}, sfield} : {64'd0, field};
    fac = {{96{d.factor[31]}}, d.factor};
    prod = mult * fac;
    acc = (prod + 128'sd32768) >>> 16;
    acc = acc + {{64{d.offset[63]}}, d.offset};
    r.status = STATUS_OK;
    r.raw_unsigned_field = field;
    r.raw_signed_field = sfield;
    if (acc[127:63] == '0 || acc[127:63] == '1) begin
      r.scaled_value = acc[63:0];
    end else begin
      r.scaled_value = acc[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  function automatic signal_def_t make_def(int unsigned ws, int unsigned wc, int unsigned sh,
                                           int unsigned wd, bit be, bit se,
                                           logic [31:0] fac, logic [63:0] off);
    signal_def_t d;
    d.win_start = 3'(ws);
    d.win_count = 4'(wc);
    d.shift = 6'(sh);
    d.width = 7'(wd);
    d.big_endian = be;
    d.sign_ext = se;
    d.factor = fac;
    d.offset = off;
    return d;
  endfunction

  function automatic frame_t make_frame(logic [63:0] bytes, int unsigned len);
    frame_t f;
    f.payload_bytes = bytes;
    f.payload_length = 4'(len);
    return f;
  endfunction

  function automatic signal_def_t rand_def();
    signal_def_t d;
    int unsigned cnt, wd;
    if ($urandom_range(0, 9) == 0) begin
      d.win_start = 3'($urandom_range(0, 7));
      d.win_count = 4'($urandom_range(0, 15));
      d.shift = 6'($urandom_range(0, 63));
      d.width = 7'($urandom_range(0, 127));
    end else begin
      cnt = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0: wd = 1;
        1: wd = 8 * cnt;
        default: wd = $urandom_range(1, 8 * cnt);
      endcase
      d.win_count = 4'(cnt);
      d.width = 7'(wd);
      d.win_start = 3'($urandom_range(0, 8 - cnt));
      d.shift = 6'($urandom_range(0, 8 * cnt - wd));
    end
    d.big_endian = 1'($urandom_range(0, 1));
    d.sign_ext = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: d.factor = 32'h7fff_ffff;
      1: d.factor = 32'h8000_0000;
      2: d.factor = 32'h0001_0000;
      3: d.factor = 32'($urandom_range(0, 262143)) - 32'h0002_0000;
      default: d.factor = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: d.offset = 64'h7fff_ffff_ffff_ffff;
      1: d.offset = 64'h8000_0000_0000_0000;
      2: d.offset = '0;
      3: d.offset = {{40{1'($urandom_range(0, 1))}}, 24'($urandom)};
      default: d.offset = {$urandom, $urandom};
    endcase
    return d;
  endfunction

  function automatic frame_t rand_frame(signal_def_t d);
    logic [63:0] bytes;
    int unsigned lo;
    case ($urandom_range(0, 9))
      0: bytes = '1;
      1: bytes = '0;
      default: bytes = {$urandom, $urandom};
    endcase
    lo = d.win_start + d.win_count;
    if (lo > 8) begin
      lo = 8;
    end
    if ($urandom_range(0, 3) == 0) begin
      return make_frame(bytes, $urandom_range(0, 15));
    end
    return make_frame(bytes, $urandom_range(8, lo));
  endfunction

  task automatic send_frame(frame_t f);
    start <= 1'b1;
    frame <= f;
    do @(posedge clk); while (busy);
    pending_decodes.push_back(decode_signal(active_def, f));
    if (gap_chance != 0 && $urandom_range(1, 8) <= gap_chance) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic program_def(signal_def_t d);
    logic [63:0] value;
    logic [2:0] idx;
    int w;
    start <= 1'b0;
    wait_for_drain();
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i);
      case (idx)
        REG_WINDOW_START: begin value = 64'(d.win_start); w = 3; end
        REG_WINDOW_COUNT: begin value = 64'(d.win_count); w = 4; end
        REG_BIT_SHIFT:    begin value = 64'(d.shift); w = 6; end
        REG_BIT_COUNT:    begin value = 64'(d.width); w = 7; end
        REG_BIG_ENDIAN:   begin value = 64'(d.big_endian); w = 1; end
        REG_SIGNED:       begin value = 64'(d.sign_ext); w = 1; end
        REG_FACTOR:       begin value = 64'(d.factor); w = 32; end
        default:          begin value = d.offset; w = 64; end
      endcase
      // Upper bits beyond the register width are junk and must be ignored.
      if (w < 64) begin
        value = value | ({$urandom, $urandom} << w);
      end
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= value;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    active_def = d;
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch on %s: expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got %h", $time, result);
        mismatches++;
      end else begin
        want = pending_decodes.pop_front();
        check_field("status", 64'(want.status), 64'(result.status));
        check_field("raw_unsigned_field", want.raw_unsigned_field, result.raw_unsigned_field);
        check_field("raw_signed_field", want.raw_signed_field, result.raw_signed_field);
        check_field("scaled_value", want.scaled_value, result.scaled_value);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[frame_signal_extractor] ERROR");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    active_def = make_def(0, 1, 0, 8, 0, 0, 32'h0001_0000, 64'd0);
    send_frame(make_frame({$urandom, $urandom}, 8));
    send_frame(make_frame(64'hffff_ffff_ffff_ff80, 1));
    send_frame(make_frame({$urandom, $urandom}, 0));
  endtask

  task automatic test_bad_definition();
    program_def(make_def(0, 0, 0, 8, 0, 0, 32'h0001_0000, 64'd5));
    send_frame(make_frame('1, 8));
    program_def(make_def(0, 15, 0, 8, 0, 0, 32'h0001_0000, 64'd5));
    send_frame(make_frame('1, 8));
    program_def(make_def(0, 8, 0, 0, 0, 0, 32'h0001_0000, 64'd5));
    send_frame(make_frame('1, 8));
    program_def(make_def(0, 8, 0, 127, 1, 1, 32'h0001_0000, 64'd5));
    send_frame(make_frame('1, 8));
    program_def(make_def(0, 2, 9, 8, 0, 0, 32'h0001_0000, 64'd5));
    send_frame(make_frame('1, 8));
  endtask

  task automatic test_window_outside();
    program_def(make_def(6, 2, 0, 16, 0, 0, 32'h0001_0000, 64'd0));
    send_frame(make_frame(64'h1234_5678_9abc_def0, 7));
    send_frame(make_frame(64'h1234_5678_9abc_def0, 8));
    send_frame(make_frame(64'h1234_5678_9abc_def0, 15));
    send_frame(make_frame(64'h1234_5678_9abc_def0, 9));
    program_def(make_def(7, 1, 0, 8, 0, 0, 32'h0001_0000, 64'd0));
    send_frame(make_frame(64'hff00_0000_0000_0000, 0));
  endtask

  task automatic test_byte_order();
    program_def(make_def(0, 8, 0, 64, 0, 0, 32'h0001_0000, 64'd0));
    send_frame(make_frame(64'h0123_4567_89ab_cdef, 8));
    program_def(make_def(0, 8, 0, 64, 1, 0, 32'h0001_0000, 64'd0));
    send_frame(make_frame(64'h0123_4567_89ab_cdef, 8));
    program_def(make_def(2, 3, 4, 13, 1, 0, 32'h0001_0000, 64'd0));
    send_frame(make_frame(64'h0123_4567_89ab_cdef, 6));
    program_def(make_def(5, 1, 1, 7, 1, 0, 32'h0001_0000, 64'd0));
    send_frame(make_frame(64'h0123_4567_89ab_cdef, 8));
  endtask

  task automatic test_signed_fields();
    program_def(make_def(1, 2, 3, 5, 0, 1, 32'h0001_0000, 64'd0));
    send_frame(make_frame(64'h0000_0000_0000_8000, 3));
    send_frame(make_frame(64'h0000_0000_0000_7f00, 3));
    program_def(make_def(0, 8, 0, 64, 0, 1, 32'h0001_0000, 64'd0));
    send_frame(make_frame(64'hffff_ffff_ffff_fff0, 8));
  endtask

  task automatic test_scaling_extremes();
    program_def(make_def(0, 8, 0, 64, 0, 0, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff));
    send_frame(make_frame('1, 8));
    program_def(make_def(0, 8, 0, 64, 0, 1, 32'h7fff_ffff, 64'h8000_0000_0000_0000));
    send_frame(make_frame(64'h8000_0000_0000_0000, 8));
    program_def(make_def(0, 8, 0, 64, 0, 1, 32'h8000_0000, 64'd0));
    send_frame(make_frame('1, 8));
    // A factor of one half puts odd fields exactly on the rounding boundary.
    program_def(make_def(0, 1, 0, 8, 0, 1, 32'h0000_8000, 64'd0));
    send_frame(make_frame(64'h01, 1));
    send_frame(make_frame(64'hff, 1));
    send_frame(make_frame(64'hfd, 1));
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 14; p++) begin
      gap_chance = $urandom_range(0, 4);
      program_def(rand_def());
      repeat ($urandom_range(20, 40)) send_frame(rand_frame(active_def));
    end
  endtask

  task automatic test_back_to_back();
    gap_chance = 0;
    for (int p = 0; p < 2; p++) begin
      program_def(rand_def());
      repeat (40) send_frame(rand_frame(active_def));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_chance = 3;
    test_reset_defaults();
    test_bad_definition();
    test_window_outside();
    test_byte_order();
    test_signed_fields();
    test_scaling_extremes();
    test_random_phases();
    test_back_to_back();
    start <= 1'b0;
    wait_for_drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("[frame_signal_extractor] OK");
    end else begin
      $display("[frame_signal_extractor] ERROR");
    end
    $finish;
  end

endmodule
